>>> sv/agbt_pkg.sv
// Package for the angular gap boundary test.
// Holds the controller/datapath command and status structs, register
// indexes, fixed datapath constants and the CORDIC arctangent table.
`timescale 1ns / 1ps

package agbt_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_U_X   = 3'd0;
    localparam logic [2:0] REG_U_Y   = 3'd1;
    localparam logic [2:0] REG_U_Z   = 3'd2;
    localparam logic [2:0] REG_V_X   = 3'd3;
    localparam logic [2:0] REG_V_Y   = 3'd4;
    localparam logic [2:0] REG_V_Z   = 3'd5;
    localparam logic [2:0] REG_THRESH = 3'd6;

    localparam logic ACT_QUERY = 1'b0;

    // projection words: 33-bit offset times 16-bit axis, three terms, CORDIC growth
    localparam int PW = 53;
    localparam logic signed [PW-1:0] NORM_HI  = 53'sh0_0001_0000_0000_0000; // 2^48
    localparam logic signed [PW-1:0] NORM_MID = 53'sh0_0000_0100_0000_0000; // 2^40

    localparam int          CORDIC_STEPS = 30;
    localparam logic [4:0]  ROT_LAST_IDX = 5'(CORDIC_STEPS - 1);
    localparam logic [31:0] ACC_HALF_TURN = 32'h8000_0000;

    typedef struct packed {
        logic load_query;
        logic skip_clear;
        logic set_drop;
        logic load_item;
        logic proj_step;
        logic norm_shift;
        logic rot_init;
        logic zero_acc;
        logic rot_step;
        logic ins_rd;
        logic ins_cmp;
        logic scan_init;
        logic scan_step;
        logic out_load;
        logic out_few;
    } agbt_cmd_t;

    typedef struct packed {
        logic skip;
        logic full;
        logic cnt_lt2;
        logic proj_last;
        logic norm_zero;
        logic norm_done;
        logic rot_last;
        logic ins_shift;
        logic scan_done;
        logic out_busy;
    } agbt_status_t;

    // atan(2^-i) in 2^-32 turn
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] t;
        case (idx)
            5'd0:  t = 32'h20000000;
            5'd1:  t = 32'h12E4051E;
            5'd2:  t = 32'h09FB385B;
            5'd3:  t = 32'h051111D4;
            5'd4:  t = 32'h028B0D43;
            5'd5:  t = 32'h0145D7E1;
            5'd6:  t = 32'h00A2F61E;
            5'd7:  t = 32'h00517C55;
            5'd8:  t = 32'h0028BE53;
            5'd9:  t = 32'h00145F2F;
            5'd10: t = 32'h000A2F98;
            5'd11: t = 32'h000517CC;
            5'd12: t = 32'h00028BE6;
            5'd13: t = 32'h000145F3;
            5'd14: t = 32'h0000A2FA;
            5'd15: t = 32'h0000517D;
            5'd16: t = 32'h000028BE;
            5'd17: t = 32'h0000145F;
            5'd18: t = 32'h00000A30;
            5'd19: t = 32'h00000518;
            5'd20: t = 32'h0000028C;
            5'd21: t = 32'h00000146;
            5'd22: t = 32'h000000A3;
            5'd23: t = 32'h00000051;
            5'd24: t = 32'h00000029;
            5'd25: t = 32'h00000014;
            5'd26: t = 32'h0000000A;
            5'd27: t = 32'h00000005;
            5'd28: t = 32'h00000003;
            5'd29: t = 32'h00000001;
            5'd30: t = 32'h00000001;
            default: t = 32'h00000000;
        endcase
        return t;
    endfunction

endpackage

>>> sv/agbt_ctrl.sv
// Sequencing state machine for the angular gap boundary test.
// Depends on agbt_pkg; drives agbt_dp through command/status structs.
`timescale 1ns / 1ps

module agbt_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_accept,
    input  logic                  in_action,
    input  logic                  in_last,
    input  agbt_pkg::agbt_status_t status,
    output agbt_pkg::agbt_cmd_t    cmd,
    output logic                  in_ready
);
    import agbt_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE    = 9'b000000001,
        ST_PROJ    = 9'b000000010,
        ST_NORM    = 9'b000000100,
        ST_ROT     = 9'b000001000,
        ST_INS_RD  = 9'b000010000,
        ST_INS_CMP = 9'b000100000,
        ST_FIN     = 9'b001000000,
        ST_SCAN    = 9'b010000000,
        ST_OUT     = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   last_reg, last_next;
    logic   few_reg, few_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        last_next  = last_reg;
        few_next   = few_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    if (in_action == ACT_QUERY) begin
                        cmd.load_query = 1'b1;
                    end else if (status.skip) begin
                        cmd.skip_clear = 1'b1;
                        if (in_last) state_next = ST_FIN;
                    end else if (status.full) begin
                        cmd.set_drop = 1'b1;
                        if (in_last) state_next = ST_FIN;
                    end else begin
                        cmd.load_item = 1'b1;
                        last_next     = in_last;
                        state_next    = ST_PROJ;
                    end
                end
            end
            ST_PROJ: begin
                cmd.proj_step = 1'b1;
                if (status.proj_last) state_next = ST_NORM;
            end
            ST_NORM: begin
                if (status.norm_zero) begin
                    cmd.zero_acc = 1'b1;
                    state_next   = ST_INS_RD;
                end else if (status.norm_done) begin
                    cmd.rot_init = 1'b1;
                    state_next   = ST_ROT;
                end else begin
                    cmd.norm_shift = 1'b1;
                end
            end
            ST_ROT: begin
                cmd.rot_step = 1'b1;
                if (status.rot_last) state_next = ST_INS_RD;
            end
            ST_INS_RD: begin
                cmd.ins_rd = 1'b1;
                state_next = ST_INS_CMP;
            end
            ST_INS_CMP: begin
                cmd.ins_cmp = 1'b1;
                if (status.ins_shift) state_next = ST_INS_RD;
                else if (last_reg)    state_next = ST_FIN;
                else                  state_next = ST_IDLE;
            end
            ST_FIN: begin
                if (status.cnt_lt2) begin
                    few_next   = 1'b1;
                    state_next = ST_OUT;
                end else begin
                    few_next      = 1'b0;
                    cmd.scan_init = 1'b1;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (status.scan_done) state_next = ST_OUT;
            end
            ST_OUT: begin
                // wait for the output register to free up
                if (!status.out_busy) begin
                    cmd.out_load = 1'b1;
                    cmd.out_few  = few_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            last_reg  <= 1'b0;
            few_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            last_reg  <= last_next;
            few_reg   <= few_next;
        end
    end

endmodule

>>> sv/agbt_dp.sv
// Datapath for the angular gap boundary test: config registers, projection,
// normalize, iterative CORDIC, sorted angle memory, gap scan, output register.
// Depends on agbt_pkg; sequenced by agbt_ctrl.
`timescale 1ns / 1ps

module agbt_dp #(
    parameter int MAX_NEIGHBORS = 64,
    parameter int ANGLE_BITS    = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [2:0]             cfg_addr,
    input  logic [15:0]            cfg_wdata,
    input  logic [31:0]            in_pos_x,
    input  logic [31:0]            in_pos_y,
    input  logic [31:0]            in_pos_z,
    input  agbt_pkg::agbt_cmd_t    cmd,
    output agbt_pkg::agbt_status_t status,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic                   out_is_boundary,
    output logic [16:0]            out_largest_gap,
    output logic                   out_too_few,
    output logic                   out_overflow
);
    import agbt_pkg::*;

    localparam int CW = $clog2(MAX_NEIGHBORS + 1);
    localparam int AW = $clog2(MAX_NEIGHBORS);
    localparam int AB = ANGLE_BITS;
    localparam logic [AB:0] FULL_TURN = (AB+1)'(1) << AB;

    // configuration
    logic [15:0] u_reg [3];
    logic [15:0] v_reg [3];
    logic [15:0] thresh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            u_reg[0]   <= 16'd16384;
            u_reg[1]   <= 16'd0;
            u_reg[2]   <= 16'd0;
            v_reg[0]   <= 16'd0;
            v_reg[1]   <= 16'd16384;
            v_reg[2]   <= 16'd0;
            thresh_reg <= 16'd16384;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_U_X:    u_reg[0]   <= cfg_wdata;
                REG_U_Y:    u_reg[1]   <= cfg_wdata;
                REG_U_Z:    u_reg[2]   <= cfg_wdata;
                REG_V_X:    v_reg[0]   <= cfg_wdata;
                REG_V_Y:    v_reg[1]   <= cfg_wdata;
                REG_V_Z:    v_reg[2]   <= cfg_wdata;
                REG_THRESH: thresh_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // run state
    logic [31:0]   q_reg [3];
    logic [31:0]   p_reg [3];
    logic [CW-1:0] count_reg;
    logic          skip_reg;
    logic          drop_reg;
    logic          clear_run;

    assign clear_run = cmd.load_query | cmd.out_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg[0]  <= '0;
            q_reg[1]  <= '0;
            q_reg[2]  <= '0;
            count_reg <= '0;
            skip_reg  <= 1'b1;
            drop_reg  <= 1'b0;
        end else begin
            if (cmd.load_query) begin
                q_reg[0] <= in_pos_x;
                q_reg[1] <= in_pos_y;
                q_reg[2] <= in_pos_z;
            end
            if (clear_run) begin
                count_reg <= '0;
                skip_reg  <= 1'b1;
                drop_reg  <= 1'b0;
            end else begin
                if (cmd.skip_clear) skip_reg <= 1'b0;
                if (cmd.set_drop)   drop_reg <= 1'b1;
                if (cmd.ins_cmp && !status.ins_shift) count_reg <= count_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            p_reg[0] <= in_pos_x;
            p_reg[1] <= in_pos_y;
            p_reg[2] <= in_pos_z;
        end
    end

    // projection: one coordinate per cycle onto both axes
    logic [1:0]             k_reg;
    logic signed [PW-1:0]   a_reg, b_reg;
    logic signed [32:0]     dx;
    logic signed [15:0]     u_sel, v_sel;
    logic signed [48:0]     pu, pv;
    logic [31:0]            acc_reg;
    logic [4:0]             i_reg;
    logic signed [PW-1:0]   da, db;
    logic [31:0]            acc_sum;
    logic [AB-1:0]          ang;

    assign dx    = $signed({p_reg[k_reg][31], p_reg[k_reg]})
                 - $signed({q_reg[k_reg][31], q_reg[k_reg]});
    assign u_sel = $signed(u_reg[k_reg]);
    assign v_sel = $signed(v_reg[k_reg]);
    assign pu    = dx * u_sel;
    assign pv    = dx * v_sel;

    assign da = b_reg >>> i_reg;
    assign db = a_reg >>> i_reg;

    // round to ANGLE_BITS, wrapping modulo a full turn
    assign acc_sum = acc_reg + (32'd1 << (31 - AB));
    assign ang     = acc_sum[31 -: AB];

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            k_reg <= 2'd0;
            a_reg <= '0;
            b_reg <= '0;
        end else if (cmd.proj_step) begin
            k_reg <= k_reg + 2'd1;
            a_reg <= a_reg + PW'(pu);
            b_reg <= b_reg + PW'(pv);
        end else if (cmd.norm_shift) begin
            if (status.norm_zero == 1'b0 &&
                a_reg < NORM_MID && a_reg > -NORM_MID &&
                b_reg < NORM_MID && b_reg > -NORM_MID) begin
                a_reg <= a_reg <<< 8;
                b_reg <= b_reg <<< 8;
            end else begin
                a_reg <= a_reg <<< 1;
                b_reg <= b_reg <<< 1;
            end
        end else if (cmd.rot_init) begin
            i_reg <= 5'd0;
            if (a_reg < 0) begin
                a_reg   <= -a_reg;
                b_reg   <= -b_reg;
                acc_reg <= ACC_HALF_TURN;
            end else begin
                acc_reg <= 32'd0;
            end
        end else if (cmd.zero_acc) begin
            acc_reg <= 32'd0;
        end else if (cmd.rot_step) begin
            i_reg <= i_reg + 5'd1;
            if (b_reg >= 0) begin
                a_reg   <= a_reg + da;
                b_reg   <= b_reg - db;
                acc_reg <= acc_reg + atan_turn(i_reg);
            end else begin
                a_reg   <= a_reg - da;
                b_reg   <= b_reg + db;
                acc_reg <= acc_reg - atan_turn(i_reg);
            end
        end
    end

    // sorted angle memory
    logic [AB-1:0] mem [MAX_NEIGHBORS];
    logic [AB-1:0] rdata;
    logic [AW-1:0] raddr, waddr;
    logic [AB-1:0] wdata;
    logic          mem_we;
    logic [CW-1:0] pos_reg;
    logic [CW-1:0] pos_m1;
    logic [CW-1:0] j_reg;

    assign pos_m1 = pos_reg - CW'(1);
    assign raddr  = cmd.scan_step ? j_reg[AW-1:0] : pos_m1[AW-1:0];
    assign waddr  = pos_reg[AW-1:0];
    assign mem_we = cmd.ins_cmp;
    assign wdata  = status.ins_shift ? rdata : ang;

    always_ff @(posedge aclk) begin
        if (mem_we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            pos_reg <= count_reg;
        end else if (cmd.ins_cmp && status.ins_shift) begin
            pos_reg <= pos_m1;
        end
    end

    // gap scan: stream the stored angles once, wrap gap at the end
    logic          rv_reg;
    logic [CW-1:0] ridx_reg;
    logic [AB-1:0] first_reg, prev_reg;
    logic [AB:0]   best_reg;
    logic          sdone_reg;
    logic [AB:0]   diff, bcand, wrap;

    assign diff  = {1'b0, rdata} - {1'b0, prev_reg};
    assign bcand = (diff > best_reg) ? diff : best_reg;
    assign wrap  = FULL_TURN - {1'b0, rdata} + {1'b0, first_reg};

    always_ff @(posedge aclk) begin
        if (cmd.scan_init) begin
            j_reg     <= '0;
            rv_reg    <= 1'b0;
            sdone_reg <= 1'b0;
        end else if (cmd.scan_step) begin
            if (j_reg < count_reg) begin
                rv_reg   <= 1'b1;
                ridx_reg <= j_reg;
                j_reg    <= j_reg + CW'(1);
            end else begin
                rv_reg <= 1'b0;
            end
            if (rv_reg) begin
                prev_reg <= rdata;
                if (ridx_reg == '0) begin
                    first_reg <= rdata;
                    best_reg  <= '0;
                end else if (ridx_reg == count_reg - CW'(1)) begin
                    best_reg  <= (wrap > bcand) ? wrap : bcand;
                    sdone_reg <= 1'b1;
                end else begin
                    best_reg <= bcand;
                end
            end
        end
    end

    // scale to 1/65536 turn
    logic [AB+16:0] gap_wide;
    logic [16:0]    gap16;
    assign gap_wide = ({16'd0, best_reg} << 16) >> AB;
    assign gap16    = gap_wide[16:0];

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid <= 1'b1;
        end else if (out_ready) begin
            out_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            if (cmd.out_few) begin
                out_is_boundary <= 1'b0;
                out_largest_gap <= '0;
                out_too_few     <= 1'b1;
                out_overflow    <= 1'b0;
            end else begin
                out_is_boundary <= gap16 > {1'b0, thresh_reg};
                out_largest_gap <= gap16;
                out_too_few     <= 1'b0;
                out_overflow    <= drop_reg;
            end
        end
    end

    assign status.skip      = skip_reg;
    assign status.full      = count_reg >= CW'(MAX_NEIGHBORS);
    assign status.cnt_lt2   = count_reg < CW'(2);
    assign status.proj_last = (k_reg == 2'd2);
    assign status.norm_zero = (a_reg == '0) && (b_reg == '0);
    assign status.norm_done = a_reg >= NORM_HI || a_reg <= -NORM_HI ||
                              b_reg >= NORM_HI || b_reg <= -NORM_HI;
    assign status.rot_last  = (i_reg == ROT_LAST_IDX);
    assign status.ins_shift = (pos_reg != '0) && (rdata > ang);
    assign status.scan_done = sdone_reg;
    assign status.out_busy  = out_valid && !out_ready;

endmodule

>>> sv/angular_gap_boundary_test.sv
// Top level of the angular gap boundary test.
// Depends on agbt_pkg, agbt_ctrl and agbt_dp.
//
// A query word loads the reference point; the neighbor words that follow are
// projected onto the configured u/v plane, turned into an angle by a 30-step
// iterative CORDIC and insertion-sorted into an on-chip angle memory. On the
// neighbor word with tlast set, the memory is scanned once for the largest
// gap (wrap gap included), or a too-few answer is given if fewer than two
// angles are stored, and one result word is sent. A stored neighbor passes
// through projection of the three coordinates, normalize shifts (none for
// large offsets), the CORDIC steps and the insertion, which moves each larger
// entry up one place in the angle memory with a read state and a compare/write
// state for each entry. Results go through an output register, so the next
// word is accepted while a result is waiting.
`timescale 1ns / 1ps

module angular_gap_boundary_test #(
    parameter int MAX_NEIGHBORS = 64,
    parameter int ANGLE_BITS    = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // pos_x[31:0], pos_y[63:32], pos_z[95:64]
    input  logic [0:0]  s_tuser,   // action[0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // is_boundary[0], largest_gap[17:1], too_few[18],
                                   // overflow[19], zero [23:20]
);
    import agbt_pkg::*;

    agbt_cmd_t    cmd;
    agbt_status_t status;
    logic         in_accept;
    logic         is_boundary, too_few, overflow;
    logic [16:0]  largest_gap;

    assign in_accept = s_tvalid && s_tready;

    agbt_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_action (s_tuser[0]),
        .in_last   (s_tlast),
        .status    (status),
        .cmd       (cmd),
        .in_ready  (s_tready)
    );

    agbt_dp #(
        .MAX_NEIGHBORS (MAX_NEIGHBORS),
        .ANGLE_BITS    (ANGLE_BITS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .in_pos_x        (s_tdata[31:0]),
        .in_pos_y        (s_tdata[63:32]),
        .in_pos_z        (s_tdata[95:64]),
        .cmd             (cmd),
        .status          (status),
        .out_ready       (m_tready),
        .out_valid       (m_tvalid),
        .out_is_boundary (is_boundary),
        .out_largest_gap (largest_gap),
        .out_too_few     (too_few),
        .out_overflow    (overflow)
    );

    assign m_tdata = {4'd0, overflow, too_few, largest_gap, is_boundary};

endmodule

>>> sv/agbt_checker.sv
// Port-level checks for angular_gap_boundary_test, attached by bind.
// No package dependency.
`timescale 1ns / 1ps

module agbt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [0:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // a query word never produces a result
    a_query_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tuser[0] |=> !$rose(m_tvalid))
        else $error("result after query word");

    // too-few answer carries no gap, boundary or overflow
    a_few_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[18] |-> m_tdata[17:0] == 18'd0 && !m_tdata[19])
        else $error("too-few result with other fields set");

    // a boundary needs a nonzero gap
    a_bnd_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[17:1] != 17'd0)
        else $error("boundary flagged with zero gap");

endmodule

bind angular_gap_boundary_test agbt_checker u_agbt_checker (.*);
